FILE: hdl/mecodo_pkg.sv
package mecodo_pkg;

  localparam int NUM_WHEELS = 4;

  // wheel order inside the lanes
  localparam int WHL_LF = 0;
  localparam int WHL_RF = 1;
  localparam int WHL_RR = 2;
  localparam int WHL_LR = 3;

  // configuration register indexes
  localparam logic [1:0] REG_SPEED_SCALE   = 2'd0;
  localparam logic [1:0] REG_OMEGA_SCALE   = 2'd1;
  localparam logic [1:0] REG_SAMPLE_PERIOD = 2'd2;

  localparam logic [31:0] SPEED_SCALE_RST   = 32'd65536;
  localparam logic [23:0] OMEGA_SCALE_RST   = 24'd41943;
  localparam logic [31:0] SAMPLE_PERIOD_RST = 32'd8589935;

  // operand / total select of the integrator
  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_T = 2'd2;

  typedef logic signed [31:0] speed_t;
  typedef logic signed [47:0] total_t;
  typedef speed_t [NUM_WHEELS-1:0] speed_vec_t;

  typedef struct packed {
    logic load;
    logic speed_en;
  } lane_ctl_t;

  typedef struct packed {
    logic mix_en;
    logic omega_en;
  } merge_ctl_t;

  typedef struct packed {
    logic       clr;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic       acc_en;
    logic [1:0] acc_sel;
  } integ_ctl_t;

  function automatic speed_t sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic total_t sat48(input logic signed [63:0] v);
    if (v > 64'sd140737488355327) begin
      return 48'sh7FFFFFFFFFFF;
    end else if (v < -64'sd140737488355328) begin
      return 48'sh800000000000;
    end
    return v[47:0];
  endfunction

endpackage

FILE: hdl/mecanum_encoder_odometry_core.sv
// Four-wheel mecanum odometry. Each input transfer carries the four encoder
// counter values; a sample (opcode 0) yields wheel speeds, body vx/vy/omega
// and the updated x/y/heading totals, a reset (opcode 1) clears the totals,
// resyncs the stored counts and returns an all-zero result. Four wheel lanes
// form deltas and speeds side by side, then a merge stage forms the body
// velocities and one shared multiplier integrates x, y and heading in turn.
// A sample steps through the speed, mix and omega states and three passes through
// the shared integration multiplier before the next ready; a reset goes straight to done.
// The finished result sits in an output register until its transfer, and the
// next item is taken once the previous result has moved into that register.
module mecanum_encoder_odometry_core #(
  parameter int COUNTER_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_opcode,
  input  logic [15:0] in_count_left_front,
  input  logic [15:0] in_count_right_front,
  input  logic [15:0] in_count_right_rear,
  input  logic [15:0] in_count_left_rear,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] out_speed_left_front,
  output logic signed [31:0] out_speed_right_front,
  output logic signed [31:0] out_speed_right_rear,
  output logic signed [31:0] out_speed_left_rear,
  output logic signed [31:0] out_body_vx,
  output logic signed [31:0] out_body_vy,
  output logic signed [31:0] out_body_omega,
  output logic signed [47:0] out_odom_x,
  output logic signed [47:0] out_odom_y,
  output logic signed [47:0] out_odom_theta,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import mecodo_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SPEED = 3'd1;
  localparam logic [2:0] ST_MIX   = 3'd2;
  localparam logic [2:0] ST_OMEGA = 3'd3;
  localparam logic [2:0] ST_INTX  = 3'd4;
  localparam logic [2:0] ST_INTY  = 3'd5;
  localparam logic [2:0] ST_INTT  = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  logic [2:0]  state_r, state_nxt;
  logic        op_r;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] speed_scale_r;
  logic [23:0] omega_scale_r;
  logic [31:0] sample_period_r;

  logic        in_xfer;
  logic        out_load;
  lane_ctl_t   lane_ctl;
  merge_ctl_t  merge_ctl;
  integ_ctl_t  integ_ctl;

  logic [15:0] counts [NUM_WHEELS];
  speed_vec_t  speeds;
  speed_t      vx, vy, omega;
  total_t      tot_x, tot_y, tot_t;

  speed_t      sp_r [NUM_WHEELS];
  speed_t      vx_r, vy_r, om_r;
  total_t      ox_r, oy_r, ot_r;

  logic        head_pend_r;
  total_t      tot_t_fin;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_load  = (state_r == ST_DONE) && !head_pend_r && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_scale_r   <= SPEED_SCALE_RST;
      omega_scale_r   <= OMEGA_SCALE_RST;
      sample_period_r <= SAMPLE_PERIOD_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SPEED_SCALE:   speed_scale_r   <= cfg_data;
        REG_OMEGA_SCALE:   omega_scale_r   <= cfg_data[23:0];
        REG_SAMPLE_PERIOD: sample_period_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_xfer) state_nxt = in_opcode ? ST_DONE : ST_SPEED;
      ST_SPEED: state_nxt = ST_MIX;
      ST_MIX:   state_nxt = ST_OMEGA;
      ST_OMEGA: state_nxt = ST_INTX;
      ST_INTX:  state_nxt = ST_INTY;
      ST_INTY:  state_nxt = ST_INTT;
      ST_INTT:  state_nxt = ST_DONE;
      default:  if (out_load) state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    lane_ctl.load      = in_xfer;
    lane_ctl.speed_en  = (state_r == ST_SPEED);
    merge_ctl.mix_en   = (state_r == ST_MIX);
    merge_ctl.omega_en = (state_r == ST_OMEGA);

    integ_ctl.clr     = in_xfer && in_opcode;
    integ_ctl.mul_en  = 1'b0;
    integ_ctl.mul_sel = AX_X;
    integ_ctl.acc_en  = 1'b0;
    integ_ctl.acc_sel = AX_X;
    // multiply one axis while accumulating the previous one
    unique case (state_r)
      ST_INTX: begin
        integ_ctl.mul_en  = 1'b1;
        integ_ctl.mul_sel = AX_X;
      end
      ST_INTY: begin
        integ_ctl.mul_en  = 1'b1;
        integ_ctl.mul_sel = AX_Y;
        integ_ctl.acc_en  = 1'b1;
        integ_ctl.acc_sel = AX_X;
      end
      ST_INTT: begin
        integ_ctl.mul_en  = 1'b1;
        integ_ctl.mul_sel = AX_T;
        integ_ctl.acc_en  = 1'b1;
        integ_ctl.acc_sel = AX_Y;
      end
      ST_DONE: begin
        integ_ctl.acc_en  = head_pend_r;
        integ_ctl.acc_sel = AX_T;
      end
      default: ;
    endcase
  end

  assign counts[WHL_LF] = in_count_left_front;
  assign counts[WHL_RF] = in_count_right_front;
  assign counts[WHL_RR] = in_count_right_rear;
  assign counts[WHL_LR] = in_count_left_rear;

  for (genvar w = 0; w < NUM_WHEELS; w++) begin : g_lane
    mecodo_lane #(
      .COUNTER_BITS(COUNTER_BITS)
    ) u_lane (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (lane_ctl),
      .count      (counts[w]),
      .speed_scale(speed_scale_r),
      .speed      (speeds[w])
    );
  end

  mecodo_merge u_merge (
    .clk        (clk),
    .ctl        (merge_ctl),
    .speeds     (speeds),
    .omega_scale(omega_scale_r),
    .vx         (vx),
    .vy         (vy),
    .omega      (omega)
  );

  mecodo_integ u_integ (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (integ_ctl),
    .vx           (vx),
    .vy           (vy),
    .omega        (omega),
    .sample_period(sample_period_r),
    .total_x      (tot_x),
    .total_y      (tot_y),
    .total_h      (tot_t)
  );

  // accumulate heading in the first done cycle, hold the result load until then
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_pend_r <= 1'b0;
    end else begin
      head_pend_r <= (state_r == ST_INTT);
    end
  end

  assign tot_t_fin = tot_t;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      op_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (in_xfer) begin
        op_r <= in_opcode;
      end
    end
  end

  // results of a reset transfer are all zero; totals were cleared at transfer
  always_ff @(posedge clk) begin
    if (out_load) begin
      for (int w = 0; w < NUM_WHEELS; w++) begin
        sp_r[w] <= op_r ? '0 : speeds[w];
      end
      vx_r <= op_r ? '0 : vx;
      vy_r <= op_r ? '0 : vy;
      om_r <= op_r ? '0 : omega;
      ox_r <= tot_x;
      oy_r <= tot_y;
      ot_r <= tot_t_fin;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_speed_left_front  = sp_r[WHL_LF];
  assign out_speed_right_front = sp_r[WHL_RF];
  assign out_speed_right_rear  = sp_r[WHL_RR];
  assign out_speed_left_rear   = sp_r[WHL_LR];
  assign out_body_vx           = vx_r;
  assign out_body_vy           = vy_r;
  assign out_body_omega        = om_r;
  assign out_odom_x            = ox_r;
  assign out_odom_y            = oy_r;
  assign out_odom_theta        = ot_r;

endmodule

FILE: hdl/mecodo_lane.sv
module mecodo_lane #(
  parameter int COUNTER_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mecodo_pkg::lane_ctl_t ctl,
  input  logic [15:0]         count,
  input  logic [31:0]         speed_scale,
  output mecodo_pkg::speed_t  speed
);
  import mecodo_pkg::*;

  // stored count width and signed delta width
  localparam int CW = (COUNTER_BITS < 16) ? COUNTER_BITS : 16;
  localparam int DW = (COUNTER_BITS > 16) ? 17 : COUNTER_BITS;

  logic [CW-1:0]        prev_r;
  logic [CW:0]          diff;
  logic signed [DW-1:0] delta_r;
  logic signed [DW+32:0] prod;
  speed_t               speed_r;

  assign diff = {1'b0, count[CW-1:0]} - {1'b0, prev_r};
  assign prod = delta_r * $signed({1'b0, speed_scale});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
    end else if (ctl.load) begin
      prev_r <= count[CW-1:0];
    end
  end

  // wrap the difference to the counter width
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      delta_r <= $signed(diff[DW-1:0]);
    end
    if (ctl.speed_en) begin
      speed_r <= sat32(64'(prod >>> 8));
    end
  end

  assign speed = speed_r;

endmodule

FILE: hdl/mecodo_merge.sv
module mecodo_merge (
  input  logic                   clk,
  input  mecodo_pkg::merge_ctl_t ctl,
  input  mecodo_pkg::speed_vec_t speeds,
  input  logic [23:0]            omega_scale,
  output mecodo_pkg::speed_t     vx,
  output mecodo_pkg::speed_t     vy,
  output mecodo_pkg::speed_t     omega
);
  import mecodo_pkg::*;

  logic signed [33:0] lf, rf, rr, lr;
  logic signed [33:0] sum_x, sum_y, sum_w;
  logic signed [33:0] wsum_r;
  logic signed [58:0] om_prod;
  speed_t             vx_r, vy_r, om_r;

  assign lf = 34'($signed(speeds[WHL_LF]));
  assign rf = 34'($signed(speeds[WHL_RF]));
  assign rr = 34'($signed(speeds[WHL_RR]));
  assign lr = 34'($signed(speeds[WHL_LR]));

  assign sum_x = lf + rf + rr + lr;
  assign sum_y = lf + lr - rf - rr;
  assign sum_w = rr + lr - rf - lf;

  assign om_prod = wsum_r * $signed({1'b0, omega_scale});

  always_ff @(posedge clk) begin
    if (ctl.mix_en) begin
      vx_r   <= sat32(64'(sum_x >>> 2));
      vy_r   <= sat32(64'(sum_y >>> 2));
      wsum_r <= sum_w;
    end
    if (ctl.omega_en) begin
      om_r <= sat32(64'(om_prod >>> 16));
    end
  end

  assign vx    = vx_r;
  assign vy    = vy_r;
  assign omega = om_r;

endmodule

FILE: hdl/mecodo_integ.sv
module mecodo_integ (
  input  logic                   clk,
  input  logic                   rst_n,
  input  mecodo_pkg::integ_ctl_t ctl,
  input  mecodo_pkg::speed_t     vx,
  input  mecodo_pkg::speed_t     vy,
  input  mecodo_pkg::speed_t     omega,
  input  logic [31:0]            sample_period,
  output mecodo_pkg::total_t     total_x,
  output mecodo_pkg::total_t     total_y,
  output mecodo_pkg::total_t     total_h
);
  import mecodo_pkg::*;

  speed_t             mul_a;
  logic signed [64:0] prod_nxt;
  logic signed [64:0] prod_r;
  logic signed [63:0] inc;
  total_t             acc_cur;
  total_t             acc_nxt;
  total_t             x_r, y_r, t_r;

  always_comb begin
    unique case (ctl.mul_sel)
      AX_X:    mul_a = vx;
      AX_Y:    mul_a = vy;
      default: mul_a = omega;
    endcase
  end

  assign prod_nxt = mul_a * $signed({1'b0, sample_period});

  // heading uses a Q0.32 period against Q16.16 omega, speeds are Q24.8
  assign inc = (ctl.acc_sel == AX_T) ? 64'(prod_r >>> 32) : 64'(prod_r >>> 24);

  always_comb begin
    unique case (ctl.acc_sel)
      AX_X:    acc_cur = x_r;
      AX_Y:    acc_cur = y_r;
      default: acc_cur = t_r;
    endcase
  end

  assign acc_nxt = sat48(64'(acc_cur) + inc);

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= prod_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr) begin
      x_r <= '0;
      y_r <= '0;
      t_r <= '0;
    end else if (ctl.acc_en) begin
      unique case (ctl.acc_sel)
        AX_X:    x_r <= acc_nxt;
        AX_Y:    y_r <= acc_nxt;
        default: t_r <= acc_nxt;
      endcase
    end
  end

  assign total_x = x_r;
  assign total_y = y_r;
  assign total_h = t_r;

endmodule
